// ----- rtl/rpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpp_pkg: shared types and constants for point rotation and projection
// Register indexes, pipeline word layout and divider stage count.
// ----------------------------------------------------------------------------
package rpp_pkg;
	localparam int unsigned NUM_REGS = 8;
	localparam int unsigned IDX_W    = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_SIN_YAW      = 3'd0,
		REG_COS_YAW      = 3'd1,
		REG_SIN_PITCH    = 3'd2,
		REG_COS_PITCH    = 3'd3,
		REG_SIN_ROLL     = 3'd4,
		REG_COS_ROLL     = 3'd5,
		REG_OFFSET_DEPTH = 3'd6,
		REG_OFFSET_PLANE = 3'd7
	} reg_idx_t;

	localparam int unsigned DIV_W    = 32; // quotient bits resolved
	localparam int unsigned BITS_PER_CELL = 2;
	localparam int unsigned NUM_CELLS = DIV_W / BITS_PER_CELL;

	localparam logic signed [31:0] DEPTH_BIAS = 32'sd216;
	localparam logic [15:0] CENTRE_X = 16'd80;
	localparam logic [15:0] CENTRE_Y = 16'd50;
	localparam logic [15:0] NO_PROJ_VALUE = 16'd255;

	// one word travelling along the divider chain
	typedef struct packed {
		logic        vld;
		logic        zero;     // divisor was zero
		logic        neg_x;    // quotient sign of x
		logic        neg_y;
		logic [15:0] dmag;     // |d|, 16 bits suffice (|d| <= 32768)
		logic [31:0] qx;       // |x3| shifting into quotient
		logic [16:0] rx;       // partial remainder
		logic [31:0] qy;
		logic [16:0] ry;
	} div_word_t;
endpackage

// ----- rtl/rpp_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpp_div_cell: one cell of the divider chain
// Resolves two quotient bits for both x and y, then hands the word on.
// ----------------------------------------------------------------------------
module rpp_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  rpp_pkg::div_word_t  din,
	output rpp_pkg::div_word_t  dout
);
	import rpp_pkg::*;

	div_word_t nxt;

	function automatic logic [16:0] step_r(input logic [16:0] r, input logic b,
		input logic [15:0] d, output logic qb);
		logic [17:0] t;
		t = {r, b} - {2'b00, d};
		qb = ~t[17];
		return t[17] ? {r[15:0], b} : t[16:0];
	endfunction

	always_comb begin
		logic [16:0] r;
		logic [31:0] q;
		logic qb;
		nxt = din;
		r = din.rx;
		q = din.qx;
		for (int i = 0; i < BITS_PER_CELL; i++) begin
			r = step_r(r, q[31], din.dmag, qb);
			q = {q[30:0], qb};
		end
		nxt.rx = r;
		nxt.qx = q;
		r = din.ry;
		q = din.qy;
		for (int i = 0; i < BITS_PER_CELL; i++) begin
			r = step_r(r, q[31], din.dmag, qb);
			q = {q[30:0], qb};
		end
		nxt.ry = r;
		nxt.qy = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end
endmodule

// ----- rtl/rpp_rotate.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpp_rotate: yaw, pitch and roll rotation with camera offsets
// Pipelined products and sums, ending in a divider entry word.
// ----------------------------------------------------------------------------
module rpp_rotate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vin,
	input  logic signed [15:0]  px,
	input  logic signed [15:0]  py,
	input  logic signed [15:0]  pz,
	input  logic signed [7:0]   sy,
	input  logic signed [7:0]   cy,
	input  logic signed [7:0]   sp,
	input  logic signed [7:0]   cp,
	input  logic signed [7:0]   sr,
	input  logic signed [7:0]   cr,
	input  logic signed [31:0]  ofs_d,
	input  logic [31:0]         ofs_p,
	output rpp_pkg::div_word_t  dout
);
	import rpp_pkg::*;

	logic [4:0] v_q;
	// stage 1: yaw products
	logic signed [31:0] zc_s1, xs_s1, xc_s1, zs_s1, y_s1;
	// stage 2: yaw sums
	logic signed [31:0] z1_s2, x1_s2, y_s2;
	// stage 3: pitch products
	logic signed [31:0] z1c_s3, ys_s3, yc_s3, z1s_s3, x1_s3;
	// stage 4: pitch sums
	logic signed [31:0] z2_s4, y2_s4, x1_s4;
	// stage 5: roll products
	logic signed [31:0] xc_s5, ysr_s5, yc_s5, xs_s5, z2_s5;
	logic signed [31:0] x3, y3, dsum;
	logic signed [15:0] d16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[3:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zc_s1 <= 32'(pz * cy);
			xs_s1 <= 32'(px * sy);
			xc_s1 <= 32'(px * cy);
			zs_s1 <= 32'(pz * sy);
			y_s1  <= 32'(py);
			z1_s2 <= (zc_s1 - xs_s1) >>> 8;
			x1_s2 <= (xc_s1 + zs_s1) >>> 8;
			y_s2  <= y_s1;
			z1c_s3 <= z1_s2 * 32'(cp);
			ys_s3  <= y_s2 * 32'(sp);
			yc_s3  <= y_s2 * 32'(cp);
			z1s_s3 <= z1_s2 * 32'(sp);
			x1_s3  <= x1_s2;
			z2_s4 <= ((z1c_s3 - (ys_s3 >>> 1)) >>> 8) + (ofs_d >>> 4);
			y2_s4 <= (yc_s3 + (z1s_s3 <<< 1)) >>> 8;
			x1_s4 <= x1_s3;
			xc_s5  <= x1_s4 * 32'(cr);
			ysr_s5 <= y2_s4 * 32'(sr);
			yc_s5  <= y2_s4 * 32'(cr);
			xs_s5  <= x1_s4 * 32'(sr);
			z2_s5  <= z2_s4;
		end
	end

	always_comb begin
		x3   = ((xc_s5 - ysr_s5) >>> 2) + (32'(signed'(ofs_p[15:0])) <<< 2);
		y3   = ((yc_s5 + xs_s5) >>> 2) - (32'(signed'(ofs_p[31:16])) <<< 2);
		dsum = z2_s5 + DEPTH_BIAS;
		d16  = dsum[15:0];
		dout.vld   = v_q[4];
		dout.zero  = (d16 == 16'sd0);
		dout.neg_x = x3[31] ^ d16[15];
		dout.neg_y = y3[31] ^ d16[15];
		dout.dmag  = d16[15] ? 16'(-d16) : 16'(d16);
		dout.qx    = x3[31] ? 32'(-x3) : 32'(x3);
		dout.qy    = y3[31] ? 32'(-y3) : 32'(y3);
		dout.rx    = '0;
		dout.ry    = '0;
	end
endmodule

// ----- rtl/rotate_project_point_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_project_point_top: 3D point rotation and perspective projection
// Rotation pipeline feeding a chain of restoring divider cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one point per word: tdata = {z, y, x}, 16 bits each.
//   m_axis carries one screen position per word: tdata = {y, x};
//   tuser = no_projection, set when the depth divisor is zero.
//   Configuration: cfg_we / cfg_idx / cfg_data write one register per clock;
//   write only while the block is idle.
// Throughput: one point per clock while the receiver keeps up. Pipeline: 22 register
//   stages (5 rotation stages, 16 divider cells of two quotient bits each, one output
//   stage); the accepting edge loads the first, and the word then passes through
//   the others in order up to the output register.
// The whole pipeline advances together; when the receiver stalls with the
//   output register full, the pipeline holds and s_axis_tready drops.
// Reset clears all valid bits and loads the default angles (identity) and
//   zero offsets.
// ----------------------------------------------------------------------------
module rotate_project_point_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // point_x, point_y, point_z
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // screen_x, screen_y
	output logic        m_axis_tuser   // no_projection
);
	import rpp_pkg::*;

	logic signed [7:0] sy_q, cy_q, sp_q, cp_q, sr_q, cr_q;
	logic signed [31:0] od_q;
	logic [31:0] op_q;
	logic en;
	div_word_t chain [NUM_CELLS+1];
	logic [15:0] sx, sy16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sy_q <= 8'sd0; cy_q <= 8'sd127;
			sp_q <= 8'sd0; cp_q <= 8'sd127;
			sr_q <= 8'sd0; cr_q <= 8'sd127;
			od_q <= '0; op_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_SIN_YAW:      sy_q <= cfg_data[7:0];
				REG_COS_YAW:      cy_q <= cfg_data[7:0];
				REG_SIN_PITCH:    sp_q <= cfg_data[7:0];
				REG_COS_PITCH:    cp_q <= cfg_data[7:0];
				REG_SIN_ROLL:     sr_q <= cfg_data[7:0];
				REG_COS_ROLL:     cr_q <= cfg_data[7:0];
				REG_OFFSET_DEPTH: od_q <= cfg_data;
				REG_OFFSET_PLANE: op_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance when the output register is free or being emptied
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	rpp_rotate u_rot (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(s_axis_tvalid),
		.px(s_axis_tdata[15:0]), .py(s_axis_tdata[31:16]), .pz(s_axis_tdata[47:32]),
		.sy(sy_q), .cy(cy_q), .sp(sp_q), .cp(cp_q), .sr(sr_q), .cr(cr_q),
		.ofs_d(od_q), .ofs_p(op_q),
		.dout(chain[0])
	);

	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		rpp_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.din(chain[g]), .dout(chain[g+1])
		);
	end

	always_comb begin
		sx   = chain[NUM_CELLS].neg_x ? 16'(-chain[NUM_CELLS].qx[15:0])
			: chain[NUM_CELLS].qx[15:0];
		sy16 = chain[NUM_CELLS].neg_y ? 16'(-chain[NUM_CELLS].qy[15:0])
			: chain[NUM_CELLS].qy[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= chain[NUM_CELLS].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (chain[NUM_CELLS].zero) begin
				m_axis_tdata <= {NO_PROJ_VALUE, NO_PROJ_VALUE};
				m_axis_tuser <= 1'b1;
			end else begin
				m_axis_tdata <= {16'(sy16 + CENTRE_Y), 16'(sx + CENTRE_X)};
				m_axis_tuser <= 1'b0;
			end
		end
	end
endmodule
